// File: design/ffcr_pkg.sv
package ffcr_pkg;

    localparam logic [7:0] BYTE_SYNC   = 8'h55;
    localparam logic [7:0] BYTE_HDR2   = 8'hFF;
    localparam logic [7:0] BYTE_TRL1   = 8'hFF;
    localparam logic [7:0] BYTE_TRL2   = 8'hFE;

    localparam logic [7:0] CMD_PAIR    = 8'h01;
    localparam logic [7:0] CMD_LIGHT   = 8'h02;
    localparam logic [7:0] CMD_STATION = 8'h03;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] pairing_value;
        logic [7:0] light_command;
        logic [7:0] station_id;
        logic [7:0] contact_state;
    } result_t;

endpackage

// File: design/fixed_frame_checksum_receiver.sv
// Channel   Dir  Handshake               Word
// --------  ---  ----------------------  ---------------------------------------------
// input     in   in_valid / in_ready     rx_byte
// result    out  out_valid / out_ready   command, pairing_value, light_command,
//                                        station_id, contact_state
//
// One word accepted per cycle, sustained unless a stalled result holds a byte
// that finishes a frame. A byte is held in the input register, then the parser
// updates frame state; a frame's last byte loads the result register, so a
// result passes the input register and then the result register.
// Reset (rst_n low, async) clears position, held values and both valid flags.
// A stalled result blocks only bytes that would finish another frame; other
// bytes keep flowing past it.
module fixed_frame_checksum_receiver #(
    parameter int FRAME_LEN = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] command,
    output logic [7:0] pairing_value,
    output logic [7:0] light_command,
    output logic [7:0] station_id,
    output logic [7:0] contact_state
);
    import ffcr_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    parse_result;
    logic       parse_done;
    logic       out_free;
    logic       step;
    logic       in_take;

    // parser: position tracking, running checksum, held fields
    ffcr_parser #(
        .FRAME_LEN (FRAME_LEN)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (s1_byte_reg),
        .step    (step),
        .done    (parse_done),
        .result  (parse_result)
    );

    // a byte retires unless it completes a frame and the result slot is full and not being read
    assign out_free = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && (!parse_done || out_free);
    assign in_ready = !s1_valid_reg || step;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (step && parse_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (step && parse_done)
        begin
            out_reg <= parse_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign command       = out_reg.command;
    assign pairing_value = out_reg.pairing_value;
    assign light_command = out_reg.light_command;
    assign station_id    = out_reg.station_id;
    assign contact_state = out_reg.contact_state;

endmodule

// File: design/ffcr_parser.sv
module ffcr_parser #(
    parameter int FRAME_LEN = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       rx_byte,
    input  logic             step,
    output logic             done,
    output ffcr_pkg::result_t result
);
    import ffcr_pkg::*;

    localparam int POS_W = $clog2(FRAME_LEN);

    localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR2 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CMD  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_B3   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_B4   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_PEND = POS_W'(FRAME_LEN - 4);
    localparam logic [POS_W-1:0] POS_CSUM = POS_W'(FRAME_LEN - 3);
    localparam logic [POS_W-1:0] POS_TRL1 = POS_W'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] POS_TRL2 = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W:0]   POS_LIM  = (POS_W+1)'(FRAME_LEN);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       b3_reg, b3_next;
    logic [7:0]       b4_reg, b4_next;
    logic [7:0]       pairing_reg, pairing_next;
    logic [7:0]       light_reg, light_next;
    logic [7:0]       station_reg, station_next;
    logic [7:0]       contact_reg, contact_next;
    logic             bad;

    always_comb
    begin
        bad = ((pos_reg == POS_HDR1) && (rx_byte != BYTE_SYNC))
           || ((pos_reg == POS_HDR2) && (rx_byte != BYTE_HDR2))
           || ((pos_reg == POS_TRL1) && (rx_byte != BYTE_TRL1))
           || ((pos_reg == POS_TRL2) && (rx_byte != BYTE_TRL2))
           || ((pos_reg == POS_CSUM) && (rx_byte != sum_reg))
           || ({1'b0, pos_reg} >= POS_LIM);
        done = !bad && (pos_reg == POS_TRL2);

        // bytes in-frame: command and payload captured as they pass
        cmd_next = (!bad && pos_reg == POS_CMD) ? rx_byte : cmd_reg;
        b3_next  = (!bad && pos_reg == POS_B3)  ? rx_byte : b3_reg;
        b4_next  = (!bad && pos_reg == POS_B4)  ? rx_byte : b4_reg;

        // running sum of command and payload bytes
        if (pos_reg == POS_CMD)
        begin
            sum_next = rx_byte;
        end
        else if (pos_reg > POS_CMD && pos_reg <= POS_PEND)
        begin
            sum_next = sum_reg + rx_byte;
        end
        else
        begin
            sum_next = sum_reg;
        end

        if (bad)
        begin
            pos_next = (rx_byte == BYTE_SYNC) ? POS_HDR2 : POS_HDR1;
        end
        else if (done)
        begin
            pos_next = POS_HDR1;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        pairing_next = pairing_reg;
        light_next   = light_reg;
        station_next = station_reg;
        contact_next = contact_reg;
        if (done)
        begin
            case (cmd_reg)
                CMD_PAIR:
                begin
                    pairing_next = b4_reg;
                end
                CMD_LIGHT:
                begin
                    light_next = b4_reg;
                end
                CMD_STATION:
                begin
                    station_next = b3_reg;
                    contact_next = b4_reg;
                end
                default:
                begin
                    pairing_next = pairing_reg;
                end
            endcase
        end

        result.command       = cmd_reg;
        result.pairing_value = pairing_next;
        result.light_command = light_next;
        result.station_id    = station_next;
        result.contact_state = contact_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_HDR1;
            pairing_reg <= 8'h00;
            light_reg   <= 8'h00;
            station_reg <= 8'h00;
            contact_reg <= 8'h00;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            pairing_reg <= pairing_next;
            light_reg   <= light_next;
            station_reg <= station_next;
            contact_reg <= contact_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sum_reg <= sum_next;
            cmd_reg <= cmd_next;
            b3_reg  <= b3_next;
            b4_reg  <= b4_next;
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < POS_LIM)
        else $error("frame position out of range");

    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> pos_reg == POS_HDR1)
        else $error("position not cleared after complete frame");

    a_sync_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        step && pos_reg == POS_HDR1 && rx_byte != BYTE_SYNC |=> pos_reg == POS_HDR1)
        else $error("left hunt state without sync byte");

endmodule
